>>> src/smbr_pkg.sv
// Package with the constants and request codes of the bounded splitmix64 generator.
`timescale 1ns / 1ps
`default_nettype none

package smbr_pkg;

  localparam int unsigned WORD_W = 64;
  localparam int unsigned DIGIT_W = 4;
  localparam int unsigned MUL_DIGITS = WORD_W / DIGIT_W;
  localparam int unsigned CNT_W = $clog2(WORD_W);

  localparam logic [WORD_W-1:0] GOLDEN_GAMMA = 64'h9e3779b97f4a7c15;
  localparam logic [WORD_W-1:0] MIX_MUL_A = 64'hbf58476d1ce4e5b9;
  localparam logic [WORD_W-1:0] MIX_MUL_B = 64'h94d049bb133111eb;

  localparam int unsigned SHIFT_A = 30;
  localparam int unsigned SHIFT_B = 27;
  localparam int unsigned SHIFT_C = 31;
  localparam int unsigned SEED_SHL = 6;
  localparam int unsigned SEED_SHR = 2;

  typedef enum logic [1:0] {
    REQ_RESEED  = 2'd0,
    REQ_RAW     = 2'd1,
    REQ_BOUNDED = 2'd2
  } req_e;

endpackage

`default_nettype wire

>>> src/splitmix64_bounded_random.sv
// Bounded splitmix64 generator: digit-serial mixer, bit-serial modulo and request sequencer.
//
// A request enters on req_valid_i / req_stall_o with req_type_i and its operands. A reseed
// request (code 0) replaces the generator state with the mix of frame_seed_i and stream_id_i
// and gives no result. A raw request (code 1) advances the state and returns the mixed word.
// A bounded request (code 2) returns a uniform value in the inclusive signed range given by
// range_min_i and range_max_i, using rejection sampling. Code 3 is taken and ignored.
// Results leave on draw_valid_o / draw_stall_i through an output register.
// The mixer multiplies by a 4-bit digit of its constant per cycle; the modulo unit resolves
// one quotient bit per cycle. A bounded request may draw more than one word before one is
// accepted; a full 64-bit range skips the modulo steps.
// One request is worked on at a time; the next is accepted once the sequencer is idle,
// even while a result still waits in the output register. A stalled receiver holds that
// result and stops the sequencer only when a second result is ready to be written.
// Reset clears the generator state to zero and empties the output register.
`timescale 1ns / 1ps
`default_nettype none

module splitmix64_bounded_random (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                req_valid_i,
  output logic                                     req_stall_o,
  input  wire logic [1:0]                          req_type_i,
  input  wire logic [smbr_pkg::WORD_W-1:0]         frame_seed_i,
  input  wire logic [smbr_pkg::WORD_W-1:0]         stream_id_i,
  input  wire logic signed [smbr_pkg::WORD_W-1:0]  range_min_i,
  input  wire logic signed [smbr_pkg::WORD_W-1:0]  range_max_i,
  output logic                                     draw_valid_o,
  input  wire logic                                draw_stall_i,
  output logic [smbr_pkg::WORD_W-1:0]              draw_value_o
);

  typedef enum logic [15:0] {
    ST_IDLE   = 16'h0001,
    ST_SWAP   = 16'h0002,
    ST_SPAN   = 16'h0004,
    ST_LIM    = 16'h0008,
    ST_ADDG   = 16'h0010,
    ST_FIN_A  = 16'h0020,
    ST_MUL_A  = 16'h0040,
    ST_FIN_B  = 16'h0080,
    ST_MUL_B  = 16'h0100,
    ST_FIN_C  = 16'h0200,
    ST_CHECK  = 16'h0400,
    ST_SEED_1 = 16'h0800,
    ST_SEED_2 = 16'h1000,
    ST_DIV    = 16'h2000,
    ST_REM    = 16'h4000,
    ST_OUT    = 16'h8000
  } state_e;

  localparam int unsigned W = smbr_pkg::WORD_W;
  localparam int unsigned DW = smbr_pkg::DIGIT_W;
  localparam int unsigned CW = smbr_pkg::CNT_W;
  localparam logic [CW-1:0] MUL_LAST = CW'(smbr_pkg::MUL_DIGITS - 1);
  localparam logic [CW-1:0] DIV_LAST = CW'(W - 1);

  state_e st_q, st_d;
  smbr_pkg::req_e op_q, op_d;
  logic pass_q, pass_d;
  logic full_q, full_d;
  logic div_final_q, div_final_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [W-1:0] rng_state_q, rng_state_d;
  logic [W-1:0] w_q, w_d;
  logic [W-1:0] seed_q, seed_d;
  logic [W-1:0] lo_q, lo_d;
  logic [W-1:0] span_q, span_d;
  logic [W-1:0] limit_q, limit_d;
  logic [W-1:0] acc_q, acc_d;
  logic [W-1:0] m_q, m_d;
  logic [W-1:0] c_q, c_d;
  logic [W-1:0] num_q, num_d;
  logic [W-1:0] rem_q, rem_d;
  logic out_valid_q, out_valid_d;
  logic [W-1:0] out_value_q, out_value_d;

  logic req_accept;
  logic [W-1:0] pp;
  logic [W:0] rem_shift;
  logic [W:0] rem_diff;
  logic [W-1:0] rem_next;
  logic [W-1:0] span_calc;
  logic [W-1:0] fin_a;
  logic [W-1:0] fin_b;
  logic out_free;

  assign req_stall_o = (st_q != ST_IDLE);
  assign req_accept = req_valid_i && !req_stall_o;
  assign draw_valid_o = out_valid_q;
  assign draw_value_o = out_value_q;
  assign out_free = !out_valid_q || !draw_stall_i;

  assign pp = m_q * W'(c_q[DW-1:0]);
  assign rem_shift = {rem_q, num_q[W-1]};
  assign rem_diff = rem_shift - {1'b0, span_q};
  assign rem_next = rem_diff[W] ? rem_shift[W-1:0] : rem_diff[W-1:0];
  assign span_calc = span_q - lo_q + W'(1);
  assign fin_a = w_q ^ (w_q >> smbr_pkg::SHIFT_A);
  assign fin_b = acc_q ^ (acc_q >> smbr_pkg::SHIFT_B);

  always_comb begin
    st_d = st_q;
    op_d = op_q;
    pass_d = pass_q;
    full_d = full_q;
    div_final_d = div_final_q;
    cnt_d = cnt_q;
    rng_state_d = rng_state_q;
    w_d = w_q;
    seed_d = seed_q;
    lo_d = lo_q;
    span_d = span_q;
    limit_d = limit_q;
    acc_d = acc_q;
    m_d = m_q;
    c_d = c_q;
    num_d = num_q;
    rem_d = rem_q;
    out_valid_d = out_valid_q && draw_stall_i;
    out_value_d = out_value_q;

    unique case (st_q) inside
      ST_IDLE: begin
        if (req_accept) begin
          unique case (req_type_i)
            smbr_pkg::REQ_RESEED: begin
              op_d = smbr_pkg::REQ_RESEED;
              pass_d = 1'b0;
              w_d = stream_id_i;
              seed_d = frame_seed_i;
              st_d = ST_ADDG;
            end
            smbr_pkg::REQ_RAW: begin
              op_d = smbr_pkg::REQ_RAW;
              full_d = 1'b0;
              st_d = ST_ADDG;
            end
            smbr_pkg::REQ_BOUNDED: begin
              op_d = smbr_pkg::REQ_BOUNDED;
              lo_d = range_min_i;
              span_d = range_max_i;
              st_d = ST_SWAP;
            end
            default: begin
              st_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_SWAP: begin
        if ($signed(span_q) < $signed(lo_q)) begin
          lo_d = span_q;
          span_d = lo_q;
        end
        st_d = ST_SPAN;
      end
      ST_SPAN: begin
        span_d = span_calc;
        full_d = (span_calc == '0);
        st_d = (span_calc == '0) ? ST_ADDG : ST_LIM;
      end
      ST_LIM: begin
        num_d = '0 - span_q;
        rem_d = '0;
        cnt_d = '0;
        div_final_d = 1'b0;
        st_d = ST_DIV;
      end
      ST_ADDG: begin
        if (op_q == smbr_pkg::REQ_RESEED) begin
          w_d = w_q + smbr_pkg::GOLDEN_GAMMA;
        end else begin
          w_d = rng_state_q + smbr_pkg::GOLDEN_GAMMA;
          rng_state_d = rng_state_q + smbr_pkg::GOLDEN_GAMMA;
        end
        st_d = ST_FIN_A;
      end
      ST_FIN_A: begin
        m_d = fin_a;
        c_d = smbr_pkg::MIX_MUL_A;
        acc_d = '0;
        cnt_d = '0;
        st_d = ST_MUL_A;
      end
      ST_MUL_A, ST_MUL_B: begin
        acc_d = acc_q + pp;
        m_d = m_q << DW;
        c_d = c_q >> DW;
        cnt_d = cnt_q + CW'(1);
        if (cnt_q == MUL_LAST) begin
          st_d = (st_q == ST_MUL_A) ? ST_FIN_B : ST_FIN_C;
        end
      end
      ST_FIN_B: begin
        m_d = fin_b;
        c_d = smbr_pkg::MIX_MUL_B;
        acc_d = '0;
        cnt_d = '0;
        st_d = ST_MUL_B;
      end
      ST_FIN_C: begin
        w_d = acc_q ^ (acc_q >> smbr_pkg::SHIFT_C);
        st_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (op_q == smbr_pkg::REQ_RESEED) begin
          if (pass_q) begin
            rng_state_d = w_q;
            st_d = ST_IDLE;
          end else begin
            pass_d = 1'b1;
            st_d = ST_SEED_1;
          end
        end else if (op_q == smbr_pkg::REQ_RAW || full_q) begin
          st_d = ST_OUT;
        end else if (w_q < limit_q) begin
          st_d = ST_ADDG;
        end else begin
          num_d = w_q;
          rem_d = '0;
          cnt_d = '0;
          div_final_d = 1'b1;
          st_d = ST_DIV;
        end
      end
      ST_SEED_1: begin
        w_d = w_q + smbr_pkg::GOLDEN_GAMMA + (seed_q << smbr_pkg::SEED_SHL);
        st_d = ST_SEED_2;
      end
      ST_SEED_2: begin
        w_d = seed_q ^ (w_q + (seed_q >> smbr_pkg::SEED_SHR));
        st_d = ST_ADDG;
      end
      ST_DIV: begin
        rem_d = rem_next;
        num_d = num_q << 1;
        cnt_d = cnt_q + CW'(1);
        if (cnt_q == DIV_LAST) begin
          st_d = ST_REM;
        end
      end
      ST_REM: begin
        if (div_final_q) begin
          w_d = lo_q + rem_q;
          st_d = ST_OUT;
        end else begin
          limit_d = rem_q;
          st_d = ST_ADDG;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_value_d = w_q;
          st_d = ST_IDLE;
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
      op_q <= smbr_pkg::REQ_RAW;
      pass_q <= 1'b0;
      full_q <= 1'b0;
      div_final_q <= 1'b0;
      cnt_q <= '0;
      rng_state_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      op_q <= op_d;
      pass_q <= pass_d;
      full_q <= full_d;
      div_final_q <= div_final_d;
      cnt_q <= cnt_d;
      rng_state_q <= rng_state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q <= w_d;
    seed_q <= seed_d;
    lo_q <= lo_d;
    span_q <= span_d;
    limit_q <= limit_d;
    acc_q <= acc_d;
    m_q <= m_d;
    c_q <= c_d;
    num_q <= num_d;
    rem_q <= rem_d;
    out_value_q <= out_value_d;
  end

  // The partial remainder of the modulo unit always stays below the divisor.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_DIV || st_q == ST_REM) |-> (rem_q < span_q))
    else $error("Partial remainder is not below the span.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_MUL_A || st_q == ST_MUL_B) |-> (cnt_q <= MUL_LAST))
    else $error("Multiplier digit count has overrun.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(draw_valid_o) |-> $past(st_q == ST_OUT))
    else $error("A result appeared without passing the output step.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_OUT) |-> (op_q != smbr_pkg::REQ_RESEED))
    else $error("A reseed request reached the output step.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_CHECK && op_q == smbr_pkg::REQ_BOUNDED && !full_q && w_q >= limit_q)
      |=> (st_q == ST_DIV && cnt_q == '0))
    else $error("An accepted draw did not start the final modulo.");

endmodule

`default_nettype wire

>>> test/splitmix64_bounded_random_test.sv
// Self-checking testbench for the bounded splitmix64 generator, with its own prediction.
`timescale 1ns / 1ps

module splitmix64_bounded_random_test;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned SETTLE_CYCLES = 300;
  localparam int unsigned SHOWN_FAULTS = 10;
  localparam logic [smbr_pkg::WORD_W-1:0] MOST_NEGATIVE = 64'h8000000000000000;
  localparam logic [smbr_pkg::WORD_W-1:0] MOST_POSITIVE = 64'h7fffffffffffffff;

  logic                                 clk_i = 1'b0;
  logic                                 rst_ni = 1'b0;
  logic                                 req_valid_i = 1'b0;
  logic                                 req_stall_o;
  logic [1:0]                           req_type_i = smbr_pkg::REQ_RAW;
  logic [smbr_pkg::WORD_W-1:0]          frame_seed_i = '0;
  logic [smbr_pkg::WORD_W-1:0]          stream_id_i = '0;
  logic signed [smbr_pkg::WORD_W-1:0]   range_min_i = '0;
  logic signed [smbr_pkg::WORD_W-1:0]   range_max_i = '0;
  logic                                 draw_valid_o;
  logic                                 draw_stall_i = 1'b0;
  logic [smbr_pkg::WORD_W-1:0]          draw_value_o;

  logic [smbr_pkg::WORD_W-1:0] model_state = '0;
  logic [smbr_pkg::WORD_W-1:0] pending_draws[$];
  logic [smbr_pkg::WORD_W-1:0] oldest_draw;
  int unsigned                 fault_count = 0;
  int unsigned                 cycle_count = 0;
  bit                          quiet = 1'b0;

  splitmix64_bounded_random u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (req_valid_i),
    .req_stall_o  (req_stall_o),
    .req_type_i   (req_type_i),
    .frame_seed_i (frame_seed_i),
    .stream_id_i  (stream_id_i),
    .range_min_i  (range_min_i),
    .range_max_i  (range_max_i),
    .draw_valid_o (draw_valid_o),
    .draw_stall_i (draw_stall_i),
    .draw_value_o (draw_value_o)
  );

  always #2 clk_i = ~clk_i;

  function automatic logic [smbr_pkg::WORD_W-1:0] rand_word();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [smbr_pkg::WORD_W-1:0] scramble(
      input logic [smbr_pkg::WORD_W-1:0] v);
    logic [smbr_pkg::WORD_W-1:0] w;
    w = (v ^ (v >> smbr_pkg::SHIFT_A)) * smbr_pkg::MIX_MUL_A;
    w = (w ^ (w >> smbr_pkg::SHIFT_B)) * smbr_pkg::MIX_MUL_B;
    return w ^ (w >> smbr_pkg::SHIFT_C);
  endfunction

  function automatic logic [smbr_pkg::WORD_W-1:0] combine_seeds(
      input logic [smbr_pkg::WORD_W-1:0] left,
      input logic [smbr_pkg::WORD_W-1:0] right);
    logic [smbr_pkg::WORD_W-1:0] inner;
    inner = scramble(right + smbr_pkg::GOLDEN_GAMMA) + smbr_pkg::GOLDEN_GAMMA
            + (left << smbr_pkg::SEED_SHL) + (left >> smbr_pkg::SEED_SHR);
    return scramble((left ^ inner) + smbr_pkg::GOLDEN_GAMMA);
  endfunction

  function automatic logic [smbr_pkg::WORD_W-1:0] step_generator();
    model_state = model_state + smbr_pkg::GOLDEN_GAMMA;
    return scramble(model_state);
  endfunction

  function automatic logic [smbr_pkg::WORD_W-1:0] ranged_draw(
      input logic [smbr_pkg::WORD_W-1:0] bound_a,
      input logic [smbr_pkg::WORD_W-1:0] bound_b);
    logic [smbr_pkg::WORD_W-1:0] low_end;
    logic [smbr_pkg::WORD_W-1:0] high_end;
    logic [smbr_pkg::WORD_W-1:0] span;
    logic [smbr_pkg::WORD_W-1:0] reject_below;
    logic [smbr_pkg::WORD_W-1:0] word;
    low_end = bound_a;
    high_end = bound_b;
    if ($signed(bound_b) < $signed(bound_a)) begin
      low_end = bound_b;
      high_end = bound_a;
    end
    span = high_end - low_end + 64'd1;
    if (span == '0) begin
      return step_generator();
    end
    reject_below = (64'd0 - span) % span;
    word = step_generator();
    while (word < reject_below) begin
      word = step_generator();
    end
    return low_end + (word % span);
  endfunction

  task automatic record_fault(input string what, input logic [smbr_pkg::WORD_W-1:0] want,
                              input logic [smbr_pkg::WORD_W-1:0] got);
    fault_count++;
    if (fault_count <= SHOWN_FAULTS) begin
      $display("%s: expected %h, got %h", what, want, got);
    end
  endtask

  task automatic expect_draw(input logic [smbr_pkg::WORD_W-1:0] value);
    pending_draws = {pending_draws, value};
  endtask

  // Each accepted request is predicted at once; the block serves requests in order.
  task automatic send_request(input logic [1:0] kind,
                              input logic [smbr_pkg::WORD_W-1:0] seed_l,
                              input logic [smbr_pkg::WORD_W-1:0] seed_r,
                              input logic [smbr_pkg::WORD_W-1:0] bound_a,
                              input logic [smbr_pkg::WORD_W-1:0] bound_b);
    if (!quiet && $urandom_range(99) < 9) begin
      req_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    req_valid_i <= 1'b1;
    req_type_i <= kind;
    frame_seed_i <= seed_l;
    stream_id_i <= seed_r;
    range_min_i <= bound_a;
    range_max_i <= bound_b;
    @(posedge clk_i);
    while (req_stall_o) @(posedge clk_i);
    case (kind)
      smbr_pkg::REQ_RESEED: model_state = combine_seeds(seed_l, seed_r);
      smbr_pkg::REQ_RAW: expect_draw(step_generator());
      smbr_pkg::REQ_BOUNDED: expect_draw(ranged_draw(bound_a, bound_b));
      default: ;
    endcase
  endtask

  task automatic send_bounded(input logic [smbr_pkg::WORD_W-1:0] bound_a,
                              input logic [smbr_pkg::WORD_W-1:0] bound_b);
    send_request(smbr_pkg::REQ_BOUNDED, rand_word(), rand_word(), bound_a, bound_b);
  endtask

  task automatic send_raw();
    send_request(smbr_pkg::REQ_RAW, rand_word(), rand_word(), rand_word(), rand_word());
  endtask

  task automatic wait_for_drain();
    req_valid_i <= 1'b0;
    while (pending_draws.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_reset_state();
    send_raw();
    send_raw();
  endtask

  task automatic test_reseed();
    send_request(smbr_pkg::REQ_RESEED, '0, '0, rand_word(), rand_word());
    send_raw();
    send_request(smbr_pkg::REQ_RESEED, '1, '1, rand_word(), rand_word());
    send_raw();
    send_request(smbr_pkg::REQ_RESEED, rand_word(), rand_word(), '0, '1);
    send_raw();
  endtask

  task automatic test_unused_code();
    send_request(REQ_UNUSED, rand_word(), rand_word(), rand_word(), rand_word());
    send_raw();
  endtask

  task automatic test_bounded_edges();
    send_bounded(MOST_NEGATIVE, MOST_NEGATIVE);
    send_bounded(MOST_POSITIVE, MOST_POSITIVE);
    send_bounded(64'sd5, -64'sd3);
    send_bounded(-64'sd1, 64'sd1);
    send_bounded(MOST_NEGATIVE, MOST_POSITIVE);
    send_bounded(MOST_POSITIVE, MOST_NEGATIVE);
    // A span of one more than half the word range rejects about half of all draws.
    repeat (3) send_bounded(MOST_NEGATIVE, '0);
    send_bounded(MOST_POSITIVE - 64'd1, MOST_POSITIVE);
    send_bounded('0, 64'd1);
    send_bounded(-64'sd7, -64'sd7);
  endtask

  task automatic send_random_item();
    logic [smbr_pkg::WORD_W-1:0] bound_a;
    logic [smbr_pkg::WORD_W-1:0] bound_b;
    logic [smbr_pkg::WORD_W-1:0] swap_word;
    int unsigned                 pick;
    pick = $urandom_range(99);
    if (pick < 10) begin
      send_request(smbr_pkg::REQ_RESEED, rand_word(), rand_word(), rand_word(), rand_word());
    end else if (pick < 45) begin
      send_raw();
    end else if (pick < 50) begin
      send_request(REQ_UNUSED, rand_word(), rand_word(), rand_word(), rand_word());
    end else begin
      bound_a = rand_word();
      case ($urandom_range(4))
        0: bound_b = rand_word();
        1: bound_b = bound_a + 64'($urandom_range(0, 300));
        2: bound_b = bound_a + ((64'd1 << $urandom_range(0, 63)) - 64'd1);
        3: begin
          bound_a = -64'($urandom_range(0, 1000));
          bound_b = 64'($urandom_range(0, 1000));
        end
        default: bound_b = bound_a + MOST_NEGATIVE + 64'($urandom_range(0, 1 << 20));
      endcase
      if ($urandom_range(99) < 30) begin
        swap_word = bound_a;
        bound_a = bound_b;
        bound_b = swap_word;
      end
      send_bounded(bound_a, bound_b);
    end
  endtask

  task automatic test_random_traffic(input int unsigned count, input bit calm);
    quiet = calm;
    repeat (count) send_random_item();
    quiet = 1'b0;
  endtask

  task automatic test_drain_pause();
    repeat (20) send_random_item();
    wait_for_drain();
    repeat (20) send_random_item();
  endtask

  always @(posedge clk_i) begin
    draw_stall_i <= rst_ni && !quiet && ($urandom_range(99) < 9);
  end

  always @(posedge clk_i) begin
    if (rst_ni && draw_valid_o && !draw_stall_i) begin
      if (pending_draws.size() == 0) begin
        record_fault("unexpected draw", '0, draw_value_o);
      end else begin
        oldest_draw = pending_draws.pop_front();
        if (oldest_draw != draw_value_o) begin
          record_fault("draw_value", oldest_draw, draw_value_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("splitmix64_bounded_random: mismatch");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_reseed();
    test_unused_code();
    test_bounded_edges();
    test_random_traffic(700, 1'b0);
    test_random_traffic(250, 1'b1);
    test_drain_pause();
    test_random_traffic(860, 1'b0);
    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fault_count == 0) begin
      $display("splitmix64_bounded_random: match");
    end else begin
      $display("splitmix64_bounded_random: mismatch");
    end
    $finish;
  end

endmodule
